[design/jbl_pkg.sv]
package jbl_pkg;

	// record kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// token types
	localparam logic [3:0] TOK_LBRACE = 4'd0;
	localparam logic [3:0] TOK_RBRACE = 4'd1;
	localparam logic [3:0] TOK_LBRACK = 4'd2;
	localparam logic [3:0] TOK_RBRACK = 4'd3;
	localparam logic [3:0] TOK_STRING = 4'd4;
	localparam logic [3:0] TOK_COLON  = 4'd5;
	localparam logic [3:0] TOK_COMMA  = 4'd6;
	localparam logic [3:0] TOK_NUMBER = 4'd7;
	localparam logic [3:0] TOK_BOOL   = 4'd8;
	localparam logic [3:0] TOK_NULL   = 4'd9;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_KEYWORD = 2'd1;
	localparam logic [1:0] ERR_INVALID = 2'd2;
	localparam logic [1:0] ERR_LENGTH  = 2'd3;

	localparam int unsigned LEN_W = 10;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd1023;

	// most records one input byte can produce
	localparam int unsigned MAX_RECS = 3;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] ttype;
		logic [7:0] lbyte;
		logic       bval;
		logic [1:0] ecode;
	} rec_t;

	// records produced by one accepted byte, lowest index goes out first
	typedef struct packed {
		logic [1:0]           cnt;
		rec_t [MAX_RECS-1:0]  recs;
	} push_t;

	function automatic rec_t mk_rec(input logic [1:0] kind, input logic [3:0] ttype,
			input logic [7:0] lbyte, input logic bval, input logic [1:0] ecode);
		rec_t r;
		r.kind  = kind;
		r.ttype = ttype;
		r.lbyte = lbyte;
		r.bval  = bval;
		r.ecode = ecode;
		return r;
	endfunction

endpackage

[design/jbl_core.sv]
module jbl_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [7:0]                    in_byte,
	input  logic                          eoi,
	input  logic [jbl_pkg::LEN_W-1:0]     max_len,
	output jbl_pkg::push_t                push
);
	import jbl_pkg::*;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_RBRK  = 8'h5d;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_L     = 8'h6c;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_LBRC  = 8'h7b;
	localparam logic [7:0] CH_RBRC  = 8'h7d;

	typedef enum logic [3:0] {
		M_IDLE, M_STR, M_INT, M_FRAC, M_EXPS, M_EXP, M_KWF, M_KWT, M_KWN
	} mode_t;

	typedef struct packed {
		logic [1:0]       cnt;
		rec_t             r0;
		rec_t             r1;
		mode_t            mode;
		logic [LEN_W-1:0] len;
		logic             err;
	} idle_t;

	mode_t            mode_q, mode_nx;
	logic [2:0]       kwp_q, kwp_nx;
	logic [LEN_W-1:0] len_q, len_nx;
	logic             err_q, err_nx;
	logic [1:0]       cnt;
	rec_t [MAX_RECS-1:0] recs;
	idle_t            id;
	logic             is_dig, take_num, ovf, kw_bad;
	mode_t            num_nx;
	logic [7:0]       kw_exp;
	logic [2:0]       kw_len;

	function automatic idle_t lex_idle(input logic [7:0] c, input logic [LEN_W-1:0] mx);
		idle_t      r;
		logic [3:0] t;
		logic       punct;
		r.cnt  = 2'd0;
		r.r0   = '0;
		r.r1   = '0;
		r.mode = M_IDLE;
		r.len  = '0;
		r.err  = 1'b0;
		punct  = 1'b1;
		case (c)
			CH_LBRC:  t = TOK_LBRACE;
			CH_RBRC:  t = TOK_RBRACE;
			CH_LBRK:  t = TOK_LBRACK;
			CH_RBRK:  t = TOK_RBRACK;
			CH_COLON: t = TOK_COLON;
			CH_COMMA: t = TOK_COMMA;
			default: begin
				t     = TOK_LBRACE;
				punct = 1'b0;
			end
		endcase
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
			r.mode = M_IDLE;
		end else if (c == CH_QUOTE) begin
			r.mode = M_STR;
		end else if (c == CH_MINUS || c == CH_PLUS || (c >= CH_ZERO && c <= CH_NINE)) begin
			r.cnt = 2'd1;
			if (mx == '0) begin
				r.r0  = mk_rec(KIND_ERR, 4'd0, 8'd0, 1'b0, ERR_LENGTH);
				r.err = 1'b1;
			end else begin
				r.r0   = mk_rec(KIND_BYTE, TOK_NUMBER, c, 1'b0, ERR_NONE);
				r.mode = M_INT;
				r.len  = LEN_W'(1);
			end
		end else if (c == CH_F) begin
			r.mode = M_KWF;
		end else if (c == CH_T) begin
			r.mode = M_KWT;
		end else if (c == CH_N) begin
			r.mode = M_KWN;
		end else if (punct) begin
			r.cnt = 2'd2;
			r.r0  = mk_rec(KIND_BYTE, t, c, 1'b0, ERR_NONE);
			r.r1  = mk_rec(KIND_END, t, 8'd0, 1'b0, ERR_NONE);
		end else begin
			r.cnt = 2'd1;
			r.r0  = mk_rec(KIND_ERR, 4'd0, 8'd0, 1'b0, ERR_INVALID);
			r.err = 1'b1;
		end
		return r;
	endfunction

	// expected keyword byte after the first one
	always_comb begin
		kw_exp = 8'd0;
		kw_len = (mode_q == M_KWF) ? 3'd4 : 3'd3;
		unique case (mode_q)
			M_KWF: begin
				case (kwp_q)
					3'd0:    kw_exp = CH_A;
					3'd1:    kw_exp = CH_L;
					3'd2:    kw_exp = CH_S;
					default: kw_exp = CH_E;
				endcase
			end
			M_KWT: begin
				case (kwp_q)
					3'd0:    kw_exp = CH_R;
					3'd1:    kw_exp = CH_U;
					default: kw_exp = CH_E;
				endcase
			end
			default: begin
				case (kwp_q)
					3'd0:    kw_exp = CH_U;
					default: kw_exp = CH_L;
				endcase
			end
		endcase
		kw_bad = (kwp_q >= kw_len) || (in_byte != kw_exp);
	end

	always_comb begin
		is_dig   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		ovf      = (len_q >= max_len);
		id       = lex_idle(in_byte, max_len);
		take_num = 1'b0;
		num_nx   = M_IDLE;
		unique case (mode_q)
			M_INT: begin
				take_num = is_dig || in_byte == CH_DOT || in_byte == CH_E;
				num_nx   = is_dig ? M_INT : (in_byte == CH_DOT ? M_FRAC : M_EXPS);
			end
			M_FRAC: begin
				take_num = is_dig || in_byte == CH_E;
				num_nx   = is_dig ? M_FRAC : M_EXPS;
			end
			M_EXPS: begin
				take_num = is_dig || in_byte == CH_MINUS || in_byte == CH_PLUS;
				num_nx   = M_EXP;
			end
			M_EXP: begin
				take_num = is_dig;
				num_nx   = M_EXP;
			end
			default: begin
				take_num = 1'b0;
				num_nx   = M_IDLE;
			end
		endcase

		mode_nx = mode_q;
		kwp_nx  = kwp_q;
		len_nx  = len_q;
		err_nx  = err_q;
		cnt     = 2'd0;
		recs    = '0;

		if (eoi) begin
			if (!err_q) begin
				unique case (mode_q)
					M_STR: begin
						cnt     = 2'd1;
						recs[0] = mk_rec(KIND_END, TOK_STRING, 8'd0, 1'b0, ERR_NONE);
					end
					M_INT, M_FRAC, M_EXPS, M_EXP: begin
						cnt     = 2'd1;
						recs[0] = mk_rec(KIND_END, TOK_NUMBER, 8'd0, 1'b0, ERR_NONE);
					end
					M_KWF, M_KWT, M_KWN: begin
						cnt     = 2'd1;
						recs[0] = mk_rec(KIND_ERR, 4'd0, 8'd0, 1'b0, ERR_KEYWORD);
					end
					default: cnt = 2'd0;
				endcase
			end
			mode_nx = M_IDLE;
			kwp_nx  = '0;
			len_nx  = '0;
			err_nx  = 1'b0;
		end else if (!err_q) begin
			unique case (mode_q)
				M_STR: begin
					cnt = 2'd1;
					if (in_byte == CH_QUOTE) begin
						recs[0] = mk_rec(KIND_END, TOK_STRING, 8'd0, 1'b0, ERR_NONE);
						mode_nx = M_IDLE;
						len_nx  = '0;
					end else if (ovf) begin
						recs[0] = mk_rec(KIND_ERR, 4'd0, 8'd0, 1'b0, ERR_LENGTH);
						err_nx  = 1'b1;
						mode_nx = M_IDLE;
						len_nx  = '0;
						kwp_nx  = '0;
					end else begin
						recs[0] = mk_rec(KIND_BYTE, TOK_STRING, in_byte, 1'b0, ERR_NONE);
						len_nx  = len_q + LEN_W'(1);
					end
				end
				M_INT, M_FRAC, M_EXPS, M_EXP: begin
					if (take_num && ovf) begin
						cnt     = 2'd1;
						recs[0] = mk_rec(KIND_ERR, 4'd0, 8'd0, 1'b0, ERR_LENGTH);
						err_nx  = 1'b1;
						mode_nx = M_IDLE;
						len_nx  = '0;
						kwp_nx  = '0;
					end else if (take_num) begin
						cnt     = 2'd1;
						recs[0] = mk_rec(KIND_BYTE, TOK_NUMBER, in_byte, 1'b0, ERR_NONE);
						mode_nx = num_nx;
						len_nx  = len_q + LEN_W'(1);
					end else begin
						// number closed, the ending byte is lexed again from idle
						cnt     = id.cnt + 2'd1;
						recs[0] = mk_rec(KIND_END, TOK_NUMBER, 8'd0, 1'b0, ERR_NONE);
						recs[1] = id.r0;
						recs[2] = id.r1;
						mode_nx = id.mode;
						len_nx  = id.len;
						err_nx  = id.err;
						kwp_nx  = '0;
					end
				end
				M_KWF, M_KWT, M_KWN: begin
					if (kw_bad) begin
						cnt     = 2'd1;
						recs[0] = mk_rec(KIND_ERR, 4'd0, 8'd0, 1'b0, ERR_KEYWORD);
						err_nx  = 1'b1;
						mode_nx = M_IDLE;
						len_nx  = '0;
						kwp_nx  = '0;
					end else if (kwp_q + 3'd1 == kw_len) begin
						cnt     = 2'd1;
						recs[0] = (mode_q == M_KWN)
							? mk_rec(KIND_END, TOK_NULL, 8'd0, 1'b0, ERR_NONE)
							: mk_rec(KIND_END, TOK_BOOL, 8'd0, mode_q == M_KWT, ERR_NONE);
						mode_nx = M_IDLE;
						kwp_nx  = '0;
					end else begin
						kwp_nx = kwp_q + 3'd1;
					end
				end
				default: begin
					cnt     = id.cnt;
					recs[0] = id.r0;
					recs[1] = id.r1;
					mode_nx = id.mode;
					len_nx  = id.len;
					err_nx  = id.err;
					kwp_nx  = '0;
				end
			endcase
		end
	end

	assign push.cnt  = take ? cnt : 2'd0;
	assign push.recs = recs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			kwp_q  <= '0;
			len_q  <= '0;
			err_q  <= 1'b0;
		end else if (take) begin
			mode_q <= mode_nx;
			kwp_q  <= kwp_nx;
			len_q  <= len_nx;
			err_q  <= err_nx;
		end
	end

	a_sticky_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take && err_q && !eoi |-> push.cnt == 2'd0)
		else $error("records produced while error is sticky");

	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && eoi |=> mode_q == M_IDLE && !err_q && len_q == '0 && kwp_q == '0)
		else $error("end of input did not return lexer to reset state");

	a_err_sets_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 && push.recs[0].kind == KIND_ERR && !eoi |=> err_q)
		else $error("error record without sticky error");

endmodule

[design/jbl_fifo.sv]
module jbl_fifo #(
	parameter int unsigned DEPTH = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  jbl_pkg::push_t push,
	input  logic           pop_ready,
	output jbl_pkg::rec_t  head,
	output logic           head_valid,
	output logic           room
);
	import jbl_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - MAX_RECS);

	rec_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] wa [MAX_RECS+1];
	logic          pop;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_comb begin
		wa[0] = wr_ptr_q;
		for (int i = 1; i <= MAX_RECS; i++) begin
			wa[i] = wrap_inc(wa[i-1]);
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign room       = (count_q <= ROOM_LIMIT);
	assign pop        = head_valid && pop_ready;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RECS; i++) begin
			if (2'(i) < push.cnt) begin
				mem_q[wa[i]] <= push.recs[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wa[push.cnt];
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> count_q <= ROOM_LIMIT)
		else $error("record queue written without room");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("record queue count beyond depth");

endmodule

[design/json_byte_lexer_unit.sv]
// Channel | Dir | Handshake                  | Payload
// s       | in  | s_tvalid / s_tready        | s_tdata = in_byte, s_tlast = end_of_input
// m       | out | m_tvalid / m_tready        | m_tuser = rec_kind, m_tdata = record fields
// cfg     | in  | cfg_valid / cfg_ready      | cfg_data = max_lexeme_len
//
// One input byte per cycle is taken while the record queue has room for three records.
// A byte is lexed in the cycle it is accepted; its 0..3 records go into the queue and
// leave on m in order. Output is one record per cycle while m_tready is high, so the
// sustained rate is one byte per cycle for bytes giving at most one record, and lower
// for bytes giving more. arst_n clears the lexer state and the queue; max_lexeme_len
// resets to 1023. A stalled m side fills the queue, and s_tready drops until room frees.
module json_byte_lexer_unit #(
	parameter int unsigned QUEUE_DEPTH = 8   // record queue entries, at least 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] in_byte
	input  logic        s_tlast,    // end_of_input
	// record stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [3:0] token class, [11:4] lex_byte, [12] bool_value,
	                                // [14:13] error_code, [15] zero
	output logic [1:0]  m_tuser,    // [1:0] rec_kind
	// max lexeme length register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data    // [9:0] max_lexeme_len
);
	import jbl_pkg::*;

	logic [LEN_W-1:0] max_len_q;
	logic             take;
	logic             room;
	push_t            push;
	rec_t             head;

	// register writes are always taken; software must write only while idle, not enforced here
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// a transaction on s runs the lexer step for that byte
	assign s_tready = room;
	assign take     = s_tvalid && s_tready;

	jbl_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (s_tdata),
		.eoi     (s_tlast),
		.max_len (max_len_q),
		.push    (push)
	);

	// records of one byte go in together; head of queue drives m
	jbl_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop_ready  (m_tready),
		.head       (head),
		.head_valid (m_tvalid),
		.room       (room)
	);

	assign m_tuser = head.kind;
	assign m_tdata = {1'b0, head.ecode, head.bval, head.lbyte, head.ttype};

endmodule

[bench/tb_json_byte_lexer_unit.sv]
import jbl_pkg::*;

// Closing quote of a string, also the opening one.
localparam logic [7:0] CH_QUOTE = 8'h22;

// Lexer modes tracked by the predictor, idle first so a fresh board starts there.
typedef enum logic [3:0] {
	LX_IDLE,
	LX_STRING,
	LX_INT,
	LX_FRAC,
	LX_EXP_START,
	LX_EXP,
	LX_KW_FALSE,
	LX_KW_TRUE,
	LX_KW_NULL
} lex_mode_e;

// Predicts the token records for each accepted byte transaction and checks the
// record transactions leaving the block against them, oldest first.
class token_scoreboard;
	localparam logic [3:0] NO_TOKEN = 4'd0;  // token type carried by error records

	rec_t       token_q[$];      // records still owed by the block
	logic [9:0] max_len;
	lex_mode_e  mode;
	logic [2:0] kw_matched;      // keyword bytes matched after the first
	logic [9:0] lex_len;         // bytes held by the open string or number
	logic       err_sticky;
	int         fail_count;

	function new();
		max_len    = MAX_LEN_RESET;
		mode       = LX_IDLE;
		kw_matched = '0;
		lex_len    = '0;
		err_sticky = 1'b0;
		fail_count = 0;
	endfunction

	function void owe(logic [1:0] kind, logic [3:0] tt, logic [7:0] b, logic bv,
			logic [1:0] ec);
		rec_t r;
		r.kind  = kind;
		r.ttype = tt;
		r.lbyte = b;
		r.bval  = bv;
		r.ecode = ec;
		token_q.push_back(r);
	endfunction

	function void fault(logic [1:0] code);
		owe(KIND_ERR, NO_TOKEN, 8'd0, 1'b0, code);
		err_sticky = 1'b1;
		mode       = LX_IDLE;
		lex_len    = '0;
		kw_matched = '0;
	endfunction

	// one byte into the open string or number, or overflow
	function void grow(logic [3:0] tt, logic [7:0] c);
		if (lex_len >= max_len) begin
			fault(ERR_LENGTH);
			return;
		end
		owe(KIND_BYTE, tt, c, 1'b0, ERR_NONE);
		lex_len = lex_len + 10'd1;
	endfunction

	function bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function void start_token(logic [7:0] c);
		logic [3:0] tt;
		if (c == " " || (c >= 8'd9 && c <= 8'd13))
			return;
		if (c == CH_QUOTE) begin
			mode    = LX_STRING;
			lex_len = '0;
			return;
		end
		if (c == "-" || c == "+" || is_digit(c)) begin
			mode    = LX_INT;
			lex_len = '0;
			grow(TOK_NUMBER, c);
			return;
		end
		if (c == "f" || c == "t" || c == "n") begin
			mode       = (c == "f") ? LX_KW_FALSE : (c == "t") ? LX_KW_TRUE : LX_KW_NULL;
			kw_matched = '0;
			return;
		end
		case (c)
			"{": tt = TOK_LBRACE;
			"}": tt = TOK_RBRACE;
			"[": tt = TOK_LBRACK;
			"]": tt = TOK_RBRACK;
			":": tt = TOK_COLON;
			",": tt = TOK_COMMA;
			default: begin
				fault(ERR_INVALID);
				return;
			end
		endcase
		owe(KIND_BYTE, tt, c, 1'b0, ERR_NONE);
		owe(KIND_END, tt, 8'd0, 1'b0, ERR_NONE);
	endfunction

	// Returns 1 when the byte is swallowed by a pending error.
	function bit note_byte(logic [7:0] c, logic eoi);
		string     kw_tail;
		bit        take;
		lex_mode_e nxt;
		if (eoi) begin
			if (!err_sticky) begin
				case (mode)
					LX_STRING: owe(KIND_END, TOK_STRING, 8'd0, 1'b0, ERR_NONE);
					LX_INT, LX_FRAC, LX_EXP_START, LX_EXP:
						owe(KIND_END, TOK_NUMBER, 8'd0, 1'b0, ERR_NONE);
					LX_KW_FALSE, LX_KW_TRUE, LX_KW_NULL:
						owe(KIND_ERR, NO_TOKEN, 8'd0, 1'b0, ERR_KEYWORD);
					default: ;
				endcase
			end
			mode       = LX_IDLE;
			kw_matched = '0;
			lex_len    = '0;
			err_sticky = 1'b0;
			return 1'b0;
		end
		if (err_sticky)
			return 1'b1;
		take = 1'b0;
		nxt  = LX_IDLE;
		case (mode)
			LX_STRING: begin
				if (c == CH_QUOTE) begin
					owe(KIND_END, TOK_STRING, 8'd0, 1'b0, ERR_NONE);
					mode    = LX_IDLE;
					lex_len = '0;
				end else begin
					grow(TOK_STRING, c);
				end
				return 1'b0;
			end
			LX_INT: begin
				if (is_digit(c)) begin
					take = 1'b1;
					nxt  = LX_INT;
				end else if (c == ".") begin
					take = 1'b1;
					nxt  = LX_FRAC;
				end else if (c == "e") begin
					take = 1'b1;
					nxt  = LX_EXP_START;
				end
			end
			LX_FRAC: begin
				if (is_digit(c)) begin
					take = 1'b1;
					nxt  = LX_FRAC;
				end else if (c == "e") begin
					take = 1'b1;
					nxt  = LX_EXP_START;
				end
			end
			LX_EXP_START: begin
				if (c == "-" || c == "+" || is_digit(c)) begin
					take = 1'b1;
					nxt  = LX_EXP;
				end
			end
			LX_EXP: begin
				if (is_digit(c)) begin
					take = 1'b1;
					nxt  = LX_EXP;
				end
			end
			LX_KW_FALSE, LX_KW_TRUE, LX_KW_NULL: begin
				kw_tail = (mode == LX_KW_FALSE) ? "alse" : (mode == LX_KW_TRUE) ? "rue" : "ull";
				if (kw_matched >= kw_tail.len() || c != kw_tail[kw_matched]) begin
					fault(ERR_KEYWORD);
					return 1'b0;
				end
				if (kw_matched + 1 == kw_tail.len()) begin
					if (mode == LX_KW_NULL)
						owe(KIND_END, TOK_NULL, 8'd0, 1'b0, ERR_NONE);
					else
						owe(KIND_END, TOK_BOOL, 8'd0, mode == LX_KW_TRUE, ERR_NONE);
					mode       = LX_IDLE;
					kw_matched = '0;
				end else begin
					kw_matched = kw_matched + 3'd1;
				end
				return 1'b0;
			end
			default: begin
				mode = LX_IDLE;
				start_token(c);
				return 1'b0;
			end
		endcase
		if (take) begin
			mode = nxt;
			grow(TOK_NUMBER, c);
			return 1'b0;
		end
		// number closed by this byte, which then starts over from idle
		owe(KIND_END, TOK_NUMBER, 8'd0, 1'b0, ERR_NONE);
		mode    = LX_IDLE;
		lex_len = '0;
		start_token(c);
		return 1'b0;
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	function void check_record(logic [1:0] user, logic [15:0] data);
		rec_t want;
		if (token_q.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected record, expected none actual kind %0d data %h",
				$time, user, data);
			return;
		end
		want = token_q.pop_front();
		compare_field("rec_kind", 32'(want.kind), 32'(user));
		compare_field("tok_class", 32'(want.ttype), 32'(data[3:0]));
		compare_field("lex_byte", 32'(want.lbyte), 32'(data[11:4]));
		compare_field("bool_value", 32'(want.bval), 32'(data[12]));
		compare_field("error_code", 32'(want.ecode), 32'(data[14:13]));
		compare_field("tdata pad bit", 0, 32'(data[15]));
	endfunction
endclass

module tb_json_byte_lexer_unit;
	// Every block input holds a known value from time zero.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [7:0]  s_tdata   = 8'd0;
	logic        s_tlast   = 1'b0;
	logic        m_tready  = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [9:0]  cfg_data  = 10'd0;
	logic        s_tready;
	logic        m_tvalid;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_ready;

	token_scoreboard board = new();

	bit squeeze_output = 1'b0;  // asks the record sink for one long hold-off
	int live_items     = 0;     // byte transactions the lexer actually acted on

	json_byte_lexer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Hard stop well past the slowest legal run, long strings and stalls included.
	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// One byte transaction. Valid is dropped only when a gap is drawn, so a
	// back-to-back item never sees valid lowered and raised in one step.
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eoi;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (!board.note_byte(b, eoi))
			live_items++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	// Quote, random body with no quote inside, then closing quote or end of input.
	task automatic send_string(input int len, input bit closed);
		int i;
		logic [7:0] c;
		send_byte(CH_QUOTE, 1'b0);
		for (i = 0; i < len; i++) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_QUOTE)
				c = 8'h5c;
			send_byte(c, 1'b0);
		end
		send_byte(closed ? CH_QUOTE : 8'($urandom_range(0, 255)), !closed);
	endtask

	// The register only moves once the lexer has drained: all owed records out,
	// then a short pause for anything still in flight.
	task automatic write_max_len(input logic [9:0] v);
		s_tvalid <= 1'b0;
		while (board.token_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid   <= 1'b0;
		board.max_len = v;
	endtask

	// Mostly well-formed tokens with random content; some noise, broken
	// keywords, unclosed strings and ends of input mixed in.
	task automatic send_random_token();
		int pick, n, i, cut, bad_at;
		string kw;
		logic [7:0] c;
		// after an error everything is swallowed, so end the text soon
		if (board.err_sticky && $urandom_range(0, 1)) begin
			send_byte(8'($urandom_range(0, 255)), 1'b1);
			return;
		end
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		end else if (pick < 11) begin
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		end else if (pick < 19) begin
			n = $urandom_range(0, 5);
			send_byte(n == 5 ? 8'h20 : 8'(9 + n), 1'b0);
		end else if (pick < 44) begin
			kw = "{}[]:,";
			send_byte(kw[$urandom_range(0, 5)], 1'b0);
		end else if (pick < 63) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
			send_string(n, $urandom_range(0, 19) != 0);
		end else if (pick < 84) begin
			// [sign] digits [. digits] [e [sign] digits]; left open for the next token
			n = $urandom_range(0, 2);
			if (n != 0)
				send_byte(n == 1 ? "-" : "+", 1'b0);
			cut = $urandom_range(n != 0 ? 0 : 1, 4);
			for (i = 0; i < cut; i++)
				send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
			if ($urandom_range(0, 2) == 0) begin
				send_byte(".", 1'b0);
				cut = $urandom_range(0, 3);
				for (i = 0; i < cut; i++)
					send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
			end
			if ($urandom_range(0, 2) == 0) begin
				send_byte("e", 1'b0);
				n = $urandom_range(0, 2);
				if (n != 0)
					send_byte(n == 1 ? "-" : "+", 1'b0);
				cut = $urandom_range(0, 3);
				for (i = 0; i < cut; i++)
					send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
			end
		end else begin
			n  = $urandom_range(0, 2);
			kw = (n == 0) ? "true" : (n == 1) ? "false" : "null";
			cut    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, kw.len() - 1) : kw.len();
			bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, kw.len() - 1) : 0;
			for (i = 0; i < cut; i++) begin
				c = (i == bad_at && i != 0) ? 8'($urandom_range(0, 255)) : 8'(kw[i]);
				send_byte(c, 1'b0);
			end
			if (cut < kw.len())
				send_byte(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	// Record sink: a random stall before each record transaction, and one long
	// hold-off whenever it is asked for.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (squeeze_output) begin
				squeeze_output = 1'b0;
				stall = 60;
			end else begin
				stall = $urandom_range(0, 4);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			board.check_record(m_tuser, m_tdata);
		end
	end

	// Reset, directed text, random phases over several register settings, then
	// one string a byte longer than its setting allows.
	initial begin
		int phase, target;
		logic [9:0] setting;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// punctuation, a string holding byte zero and 0xff, a full number closed
		// by a bracket, and a keyword cut short by end of input
		write_max_len(10'd1023);
		send_text("{}[]:,");
		send_byte(CH_QUOTE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_text("-1.5e+9]");
		send_text("tru");
		send_byte(8'h00, 1'b1);

		// one-byte lexemes: string overflow then swallowed bytes, lone signs,
		// keyword mismatch, invalid byte, a string left open at the end
		write_max_len(10'd1);
		send_text("\"abx");
		send_byte(8'h00, 1'b1);
		send_text("-");
		send_byte(8'hff, 1'b1);
		send_text("+,");
		send_text("nux");
		send_byte(8'h00, 1'b1);
		send_text("#");
		send_byte(8'hff, 1'b1);
		send_string(0, 1'b0);

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: setting = 10'd1023;
				1: setting = 10'd1;
				2: setting = 10'd4;
				3: setting = 10'd300;
				4: setting = 10'd2;
				default: setting = 10'd1023;
			endcase
			write_max_len(setting);
			// a stalled sink while bytes keep coming backs up the record queue
			if (phase == 2 || phase == 4)
				squeeze_output = 1'b1;
			target = live_items + 50;
			while (live_items < target)
				send_random_token();
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		end

		// 40 bytes fit, the next one overflows, the rest is swallowed
		write_max_len(10'd40);
		send_string(41, 1'b1);
		send_byte(8'h00, 1'b1);

		s_tvalid <= 1'b0;
		while (board.token_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

[json_byte_lexer_unit.f]
design/jbl_pkg.sv
design/jbl_core.sv
design/jbl_fifo.sv
design/json_byte_lexer_unit.sv
bench/tb_json_byte_lexer_unit.sv
